[hdl/cfpp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpp_pkg: shared types and constants of the CRC-16 framed packet parser
// Parse phases, queue entry and result record, and the CRC byte update.
// ----------------------------------------------------------------------------
package cfpp_pkg;

  localparam logic [15:0] CRC_INIT     = 16'hFFFF;
  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [7:0]  HEADER_RESET = 8'h55;

  // Front-to-back queue: two entries, so pointers wrap on their own.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_ID    = 3'd1,
    PH_LEN   = 3'd2,
    PH_DATA  = 3'd3,
    PH_CRCLO = 3'd4,
    PH_CRCHI = 3'd5
  } phase_e;

  // Classified byte as it waits in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       is_hdr;
  } item_t;

  // One result record
  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    logic       frame_good;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
  } res_t;

  // CRC-16/CCITT-FALSE, MSB first, one byte
  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

[hdl/cfpp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpp_if: channel interfaces of the packet parser
// Received byte, result and configuration write channels.
// ----------------------------------------------------------------------------
interface cfpp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfpp_res_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       frame_done;
  logic       frame_good;
  logic [7:0] frame_id;
  logic [7:0] frame_length;

  modport source (output valid, output payload_valid, output payload_byte,
                  output payload_index, output frame_done, output frame_good,
                  output frame_id, output frame_length, input ready);
  modport sink   (input valid, input payload_valid, input payload_byte,
                  input payload_index, input frame_done, input frame_good,
                  input frame_id, input frame_length, output ready);
endinterface

interface cfpp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/crc16_framed_packet_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc16_framed_packet_parser: byte-serial frame parser with CRC-16 check
// Header, id, length, payload and a low-first CRC-16/CCITT-FALSE trailer.
// ----------------------------------------------------------------------------
// Usage
//   rx_i  : one received byte per transaction (valid/ready).
//   res_o : exactly one result transaction per byte, in order. Payload
//           bytes come out with their index; the CRC high byte raises
//           frame_done with frame_good; frame_id/frame_length track the
//           last id and length taken.
//   cfg_i : header byte register (reset 0x55), always ready. Write it only
//           while the parser is idle; a frame already started keeps the
//           header that opened it.
// Timing
//   One byte per cycle sustained while res_o is ready. An rx byte passes
//   through the two-entry intake queue, then the result register loaded
//   by the phase machine and byte-wide CRC update.
// Reset
//   Asynchronous, active low: hunting for a header, queue empty, no result
//   pending. No clearing pass.
// Back-pressure
//   A stalled res_o holds its result; the queue absorbs up to two more
//   bytes before rx_i.ready drops.
// ----------------------------------------------------------------------------
module crc16_framed_packet_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  cfpp_cfg_if.sink   cfg_i,
  cfpp_rx_if.sink    rx_i,
  cfpp_res_if.source res_o
);

  // queue head between intake and phase machine
  logic            q_valid;
  logic            q_ready;
  cfpp_pkg::item_t q_item;

  cfpp_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .rx_i      (rx_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_ready_i (q_ready)
  );

  cfpp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_ready_o (q_ready),
    .res_o     (res_o)
  );

  // A full queue always has a byte waiting for the back end
  a_full_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rx_i.ready |-> q_valid)
    else $error("queue full but head not valid");

  // A stalled result must stop the back end from taking another byte
  a_stall_blocks_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |-> !q_ready)
    else $error("back end popped while result stalled");

  // A byte is either payload or frame end, never both; good only with done
  a_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (!(res_o.payload_valid && res_o.frame_done) &&
                     !(res_o.frame_good && !res_o.frame_done)))
    else $error("inconsistent result flags");

endmodule

[hdl/cfpp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpp_front: byte intake and classification
// Holds the header register, tags each byte against it and queues it.
// ----------------------------------------------------------------------------
module cfpp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  cfpp_cfg_if.sink        cfg_i,
  cfpp_rx_if.sink         rx_i,
  output logic            q_valid_o,
  output cfpp_pkg::item_t q_item_o,
  input  logic            q_ready_i
);

  logic [7:0]                    header_q;
  cfpp_pkg::item_t               mem_q [cfpp_pkg::QDEPTH];
  logic [cfpp_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [cfpp_pkg::QCNT_W-1:0]   cnt_q, cnt_d;
  logic                          push, pop;
  cfpp_pkg::item_t               push_item;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= cfpp_pkg::HEADER_RESET;
    end else if (cfg_i.valid) begin
      header_q <= cfg_i.data;
    end
  end

  assign rx_i.ready = (cnt_q != cfpp_pkg::QCNT_W'(cfpp_pkg::QDEPTH));
  assign push       = rx_i.valid && rx_i.ready;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    push_item.data   = rx_i.rx_byte;
    push_item.is_hdr = (rx_i.rx_byte == header_q);
  end

  always_comb begin
    cnt_d = cnt_q;
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item;
    end
  end

endmodule

[hdl/cfpp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfpp_back: frame state machine and running CRC
// Takes one queued byte per cycle while res_o is not stalled and loads the result register.
// ----------------------------------------------------------------------------
module cfpp_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  cfpp_pkg::item_t q_item_i,
  output logic            q_ready_o,
  cfpp_res_if.source      res_o
);

  cfpp_pkg::phase_e phase_q, phase_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       cnt_q, cnt_d;
  logic [7:0]       len_q, len_d;
  logic [7:0]       id_q, id_d;
  logic [7:0]       lo_q, lo_d;
  logic             res_valid_q;
  cfpp_pkg::res_t   res_q, res_d;
  logic             fire;
  logic             last_data;
  logic [7:0]       b;

  assign q_ready_o = !res_valid_q || res_o.ready;
  assign fire      = q_valid_i && q_ready_o;
  assign b         = q_item_i.data;
  assign last_data = ({1'b0, cnt_q} + 9'd1) >= {1'b0, len_q};

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      cfpp_pkg::PH_ID:    phase_d = cfpp_pkg::PH_LEN;
      cfpp_pkg::PH_LEN:   phase_d = (b == 8'd0) ? cfpp_pkg::PH_CRCLO : cfpp_pkg::PH_DATA;
      cfpp_pkg::PH_DATA:  phase_d = last_data ? cfpp_pkg::PH_CRCLO : cfpp_pkg::PH_DATA;
      cfpp_pkg::PH_CRCLO: phase_d = cfpp_pkg::PH_CRCHI;
      cfpp_pkg::PH_CRCHI: phase_d = cfpp_pkg::PH_HUNT;
      default:            phase_d = q_item_i.is_hdr ? cfpp_pkg::PH_ID : cfpp_pkg::PH_HUNT;
    endcase
  end

  // datapath and result
  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    len_d = len_q;
    id_d  = id_q;
    lo_d  = lo_q;
    res_d = '0;
    unique case (phase_q)
      cfpp_pkg::PH_ID: begin
        id_d  = b;
        crc_d = cfpp_pkg::crc16_byte(crc_q, b);
      end
      cfpp_pkg::PH_LEN: begin
        len_d = b;
        crc_d = cfpp_pkg::crc16_byte(crc_q, b);
        cnt_d = '0;
      end
      cfpp_pkg::PH_DATA: begin
        crc_d               = cfpp_pkg::crc16_byte(crc_q, b);
        res_d.payload_valid = 1'b1;
        res_d.payload_byte  = b;
        res_d.payload_index = cnt_q;
        cnt_d               = last_data ? 8'd0 : cnt_q + 8'd1;
      end
      cfpp_pkg::PH_CRCLO: begin
        lo_d = b;
      end
      cfpp_pkg::PH_CRCHI: begin
        res_d.frame_done = 1'b1;
        res_d.frame_good = ({b, lo_q} == crc_q);
      end
      default: begin
        if (q_item_i.is_hdr) begin
          crc_d = cfpp_pkg::crc16_byte(cfpp_pkg::CRC_INIT, b);
        end
      end
    endcase
    res_d.frame_id     = id_d;
    res_d.frame_length = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= cfpp_pkg::PH_HUNT;
      crc_q       <= cfpp_pkg::CRC_INIT;
      cnt_q       <= '0;
      len_q       <= '0;
      id_q        <= '0;
      lo_q        <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (q_ready_o) res_valid_q <= q_valid_i;
      if (fire) begin
        phase_q <= phase_d;
        crc_q   <= crc_d;
        cnt_q   <= cnt_d;
        len_q   <= len_d;
        id_q    <= id_d;
        lo_q    <= lo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) res_q <= res_d;
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.payload_valid = res_q.payload_valid;
  assign res_o.payload_byte  = res_q.payload_byte;
  assign res_o.payload_index = res_q.payload_index;
  assign res_o.frame_done    = res_q.frame_done;
  assign res_o.frame_good    = res_q.frame_good;
  assign res_o.frame_id      = res_q.frame_id;
  assign res_o.frame_length  = res_q.frame_length;

endmodule
